// File: sv/tea_pkg.sv
// shared types, constants and the round mixing function for the tea cipher
package tea_pkg;

  localparam int unsigned WordW = 32;
  localparam logic [WordW-1:0] Delta = 32'h9E37_79B9;

  localparam logic [WordW-1:0] KeyZeroRst = 32'd31337;
  localparam logic [WordW-1:0] KeyOneRst = 32'd62674;
  localparam logic [WordW-1:0] KeyTwoRst = 32'd125348;
  localparam logic [WordW-1:0] KeyThreeRst = 32'd250696;

  typedef enum logic {
    REQ_ENCRYPT = 1'b0,
    REQ_DECRYPT = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    KEY_ZERO = 2'd0,
    KEY_ONE = 2'd1,
    KEY_TWO = 2'd2,
    KEY_THREE = 2'd3
  } key_idx_t;

  typedef struct packed {
    logic [WordW-1:0] k0;
    logic [WordW-1:0] k1;
    logic [WordW-1:0] k2;
    logic [WordW-1:0] k3;
  } key_t;

  typedef struct packed {
    logic valid;
    req_t req;
    logic [WordW-1:0] y;
    logic [WordW-1:0] z;
  } stage_t;

  function automatic logic [WordW-1:0] mix(
    input logic [WordW-1:0] v,
    input logic [WordW-1:0] sum,
    input logic [WordW-1:0] kl,
    input logic [WordW-1:0] kr
  );
    mix = ((v << 4) + kl) ^ (v + sum) ^ ((v >> 5) + kr);
  endfunction

endpackage

// File: sv/tea_half_round.sv
// one registered half round of the tea pipeline, encrypt or decrypt
module tea_half_round #(
  parameter bit HALF = 1'b0,
  parameter logic [31:0] SUM_ENC = 32'h0,
  parameter logic [31:0] SUM_DEC = 32'h0
) (
  input  logic            clk,
  input  logic            rst,
  input  tea_pkg::key_t   key,
  input  tea_pkg::stage_t stage_in,
  output tea_pkg::stage_t stage_out
);

  logic                      is_dec;
  logic                      upd_y;
  logic [tea_pkg::WordW-1:0] src;
  logic [tea_pkg::WordW-1:0] dst;
  logic [tea_pkg::WordW-1:0] kl;
  logic [tea_pkg::WordW-1:0] kr;
  logic [tea_pkg::WordW-1:0] sum;
  logic [tea_pkg::WordW-1:0] mixed;
  logic [tea_pkg::WordW-1:0] dst_next;

  always_comb begin
    is_dec = (stage_in.req == tea_pkg::REQ_DECRYPT);
    upd_y = (HALF == 1'b0) ? !is_dec : is_dec;
    src = upd_y ? stage_in.z : stage_in.y;
    dst = upd_y ? stage_in.y : stage_in.z;
    kl = upd_y ? key.k0 : key.k2;
    kr = upd_y ? key.k1 : key.k3;
    sum = is_dec ? SUM_DEC : SUM_ENC;
    mixed = tea_pkg::mix(src, sum, kl, kr);
    dst_next = is_dec ? (dst - mixed) : (dst + mixed);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_in.valid;
    end
    stage_out.req <= stage_in.req;
    stage_out.y <= upd_y ? dst_next : stage_in.y;
    stage_out.z <= upd_y ? stage_in.z : dst_next;
  end

endmodule

// File: sv/tea_block_cipher.sv
// tea block cipher top level: key registers and the half round pipeline
// each block passes from start to done through the half round stages, one half round per stage
// throughput: one block per cycle, busy never rises, done needs no acknowledge
// reset clears the stage valid bits and loads the default key words
// the pipeline depth is set by the ROUNDS parameter
module tea_block_cipher #(
  parameter int ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [31:0] block_first,
  input  logic [31:0] block_second,
  output logic        done,
  output logic [31:0] result_first,
  output logic [31:0] result_second,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int Stages = 2 * ROUNDS;

  tea_pkg::key_t   key;
  tea_pkg::stage_t pipe [Stages+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key.k0 <= tea_pkg::KeyZeroRst;
      key.k1 <= tea_pkg::KeyOneRst;
      key.k2 <= tea_pkg::KeyTwoRst;
      key.k3 <= tea_pkg::KeyThreeRst;
    end else if (cfg_wr_en) begin
      unique case (tea_pkg::key_idx_t'(cfg_index))
        tea_pkg::KEY_ZERO:  key.k0 <= cfg_data;
        tea_pkg::KEY_ONE:   key.k1 <= cfg_data;
        tea_pkg::KEY_TWO:   key.k2 <= cfg_data;
        tea_pkg::KEY_THREE: key.k3 <= cfg_data;
        default: key <= key;
      endcase
    end
  end

  assign busy = 1'b0;

  always_comb begin
    pipe[0].valid = start && !busy;
    pipe[0].req = tea_pkg::req_t'(req_type);
    pipe[0].y = block_first;
    pipe[0].z = block_second;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    localparam int Round = s / 2;
    localparam logic [63:0] ProdEnc = 64'(tea_pkg::Delta) * 64'(Round + 1);
    localparam logic [63:0] ProdDec = 64'(tea_pkg::Delta) * 64'(ROUNDS - Round);

    tea_half_round #(
      .HALF    (1'(s % 2)),
      .SUM_ENC (ProdEnc[31:0]),
      .SUM_DEC (ProdDec[31:0])
    ) u_half (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .stage_in  (pipe[s]),
      .stage_out (pipe[s+1])
    );
  end

  assign done = pipe[Stages].valid;
  assign result_first = pipe[Stages].y;
  assign result_second = pipe[Stages].z;

endmodule
